// ===== rtl/assert_macros.svh =====
// Assertion macros for the two-level ready-list scheduler RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/bprs_pkg.sv =====
// Shared types, constants and functions of the ready-list scheduler
`default_nettype none
package bprs_pkg;

  localparam int unsigned ROW_COUNT  = 8;
  localparam int unsigned ROW_BITS   = 3;
  localparam int unsigned PRIO_BITS  = 6;
  localparam int unsigned MODE_BITS  = 3;
  localparam int unsigned LOCK_BITS  = 8;
  localparam logic [LOCK_BITS-1:0] LOCK_MAX = 8'hFF;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_READY   = 3'd0,
    MODE_UNREADY = 3'd1,
    MODE_LOCK    = 3'd2,
    MODE_UNLOCK  = 3'd3,
    MODE_SCHED   = 3'd4
  } mode_t;

  typedef struct packed {
    logic load;
    logic update;
    logic report;
  } cmd_t;

  function automatic logic [ROW_BITS-1:0] lowest_bit8(input logic [ROW_COUNT-1:0] v);
    logic [ROW_BITS-1:0] idx;
    idx = '0;
    for (int i = ROW_COUNT - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = ROW_BITS'(i);
      end
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/bprs_ctrl.sv =====
// Controller: sequences load, update and report of one word
`default_nettype none
module bprs_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  output logic                out_valid,
  output bprs_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_REPORT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_REPORT;
      end
      ST_REPORT: begin
        cmd.report    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== rtl/bprs_datapath.sv =====
// Datapath: ready bitmap, lock count, priority encode and result registers
`default_nettype none
module bprs_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire bprs_pkg::cmd_t                    cmd,
  input  wire logic [bprs_pkg::MODE_BITS-1:0]    in_mode,
  input  wire logic [bprs_pkg::PRIO_BITS-1:0]    in_priority_req,
  input  wire logic [bprs_pkg::PRIO_BITS-1:0]    in_current_prio,
  input  wire logic                              in_in_interrupt,
  input  wire logic                              in_running,
  output logic [bprs_pkg::PRIO_BITS-1:0]         out_highest_prio,
  output logic                                   out_none_ready,
  output logic                                   out_switch_needed,
  output logic [bprs_pkg::LOCK_BITS-1:0]         out_lock_level
);

  logic [bprs_pkg::MODE_BITS-1:0] mode_r;
  logic [bprs_pkg::PRIO_BITS-1:0] prio_r;
  logic [bprs_pkg::PRIO_BITS-1:0] cur_r;
  logic                           int_r;
  logic                           run_r;

  logic [bprs_pkg::ROW_COUNT-1:0] group_r;
  logic [bprs_pkg::ROW_COUNT-1:0] group_nxt;
  logic [bprs_pkg::ROW_COUNT-1:0] rows_r   [bprs_pkg::ROW_COUNT];
  logic [bprs_pkg::ROW_COUNT-1:0] rows_nxt [bprs_pkg::ROW_COUNT];
  logic [bprs_pkg::LOCK_BITS-1:0] lock_r;
  logic [bprs_pkg::LOCK_BITS-1:0] lock_nxt;
  logic                           sched_r;
  logic                           sched_nxt;

  logic [bprs_pkg::PRIO_BITS-1:0] hi_prio_r;
  logic                           none_r;
  logic                           switch_r;
  logic [bprs_pkg::LOCK_BITS-1:0] level_r;

  logic [bprs_pkg::ROW_BITS-1:0]  req_row;
  logic [bprs_pkg::ROW_COUNT-1:0] req_bit;
  logic                           gate_ok;
  logic [bprs_pkg::ROW_BITS-1:0]  hi_row;
  logic [bprs_pkg::ROW_BITS-1:0]  hi_col;
  logic [bprs_pkg::PRIO_BITS-1:0] hi_prio;

  assign req_row = prio_r[bprs_pkg::PRIO_BITS-1:bprs_pkg::ROW_BITS];
  assign req_bit = bprs_pkg::ROW_COUNT'(1) << prio_r[bprs_pkg::ROW_BITS-1:0];
  assign gate_ok = run_r && !int_r;

  // update each row in place; group bit follows its row
  always_comb begin
    lock_nxt  = lock_r;
    sched_nxt = 1'b0;
    for (int i = 0; i < bprs_pkg::ROW_COUNT; i++) begin
      rows_nxt[i] = rows_r[i];
      if (req_row == bprs_pkg::ROW_BITS'(i)) begin
        if (mode_r == bprs_pkg::MODE_READY) begin
          rows_nxt[i] = rows_r[i] | req_bit;
        end else if (mode_r == bprs_pkg::MODE_UNREADY) begin
          rows_nxt[i] = rows_r[i] & ~req_bit;
        end
      end
      group_nxt[i] = (req_row == bprs_pkg::ROW_BITS'(i)) ? |rows_nxt[i] : group_r[i];
    end
    if (mode_r == bprs_pkg::MODE_LOCK) begin
      if (gate_ok && lock_r != bprs_pkg::LOCK_MAX) begin
        lock_nxt = lock_r + 1'b1;
      end
    end else if (mode_r == bprs_pkg::MODE_UNLOCK) begin
      if (gate_ok) begin
        if (lock_r != '0) begin
          lock_nxt = lock_r - 1'b1;
        end
        sched_nxt = 1'b1;
      end
    end else if (mode_r == bprs_pkg::MODE_SCHED) begin
      sched_nxt = 1'b1;
    end
  end

  assign hi_row  = bprs_pkg::lowest_bit8(group_r);
  assign hi_col  = bprs_pkg::lowest_bit8(rows_r[hi_row]);
  assign hi_prio = {hi_row, hi_col};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      prio_r <= in_priority_req;
      cur_r  <= in_current_prio;
      int_r  <= in_in_interrupt;
      run_r  <= in_running;
    end
    if (cmd.report) begin
      hi_prio_r <= hi_prio;
      none_r    <= (group_r == '0);
      switch_r  <= sched_r && !int_r && (lock_r == '0) && (hi_prio != cur_r);
      level_r   <= lock_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r <= '0;
      lock_r  <= '0;
      sched_r <= 1'b0;
      for (int i = 0; i < bprs_pkg::ROW_COUNT; i++) begin
        rows_r[i] <= '0;
      end
    end else if (cmd.update) begin
      group_r <= group_nxt;
      lock_r  <= lock_nxt;
      sched_r <= sched_nxt;
      for (int i = 0; i < bprs_pkg::ROW_COUNT; i++) begin
        rows_r[i] <= rows_nxt[i];
      end
    end
  end

  assign out_highest_prio  = hi_prio_r;
  assign out_none_ready    = none_r;
  assign out_switch_needed = switch_r;
  assign out_lock_level    = level_r;

endmodule
`default_nettype wire

// ===== rtl/bitmap_priority_ready_scheduler_top.sv =====
// Top level of the two-level bitmap ready-list scheduler
// A word is taken when start is high and busy is low; after the capture,
// update and report states its result appears for one cycle with out_valid
// high; the receiver cannot stall, so it must capture the result in that cycle.
// Each word passes through capture, bitmap and lock update, and priority
// encode into the result registers, set by the controller sequence; a new
// word can start only once busy drops, in the cycle the result is shown.
`default_nettype none
`include "assert_macros.svh"
module bitmap_priority_ready_scheduler_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [bprs_pkg::MODE_BITS-1:0]    in_mode,
  input  wire logic [bprs_pkg::PRIO_BITS-1:0]    in_priority_req,
  input  wire logic [bprs_pkg::PRIO_BITS-1:0]    in_current_prio,
  input  wire logic                              in_in_interrupt,
  input  wire logic                              in_running,
  output logic                                   out_valid,
  output logic [bprs_pkg::PRIO_BITS-1:0]         out_highest_prio,
  output logic                                   out_none_ready,
  output logic                                   out_switch_needed,
  output logic [bprs_pkg::LOCK_BITS-1:0]         out_lock_level
);

  bprs_pkg::cmd_t cmd;

  bprs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  bprs_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_mode           (in_mode),
    .in_priority_req   (in_priority_req),
    .in_current_prio   (in_current_prio),
    .in_in_interrupt   (in_in_interrupt),
    .in_running        (in_running),
    .out_highest_prio  (out_highest_prio),
    .out_none_ready    (out_none_ready),
    .out_switch_needed (out_switch_needed),
    .out_lock_level    (out_lock_level)
  );

  `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `ASSERT_IMPLIES(a_valid_idle, clk, rst_n, out_valid, !busy)
  `ASSERT_IMPLIES(a_empty_zero, clk, rst_n, out_valid && out_none_ready, out_highest_prio == '0)
  `ASSERT_IMPLIES(a_switch_unlocked, clk, rst_n, out_valid && out_switch_needed, out_lock_level == '0)

endmodule
`default_nettype wire

// ===== tb/tb_bitmap_priority_ready_scheduler_top.sv =====
// Self-checking testbench for the two-level bitmap ready-list scheduler top level
`timescale 1ns / 100ps
module tb_bitmap_priority_ready_scheduler_top;
  import bprs_pkg::*;

  localparam logic [MODE_BITS-1:0] MODE_UNUSED_MIN = 3'd5;
  localparam logic [MODE_BITS-1:0] MODE_UNUSED_MAX = 3'd7;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic [PRIO_BITS-1:0] prio;
    logic [PRIO_BITS-1:0] cur;
    logic                 irq;
    logic                 run;
  } sched_word_t;

  typedef struct packed {
    logic [PRIO_BITS-1:0] highest;
    logic                 empty;
    logic                 switch_req;
    logic [LOCK_BITS-1:0] lock_level;
  } sched_report_t;

  class ready_list_tracker;
    bit [ROW_COUNT-1:0] group_bits;
    bit [ROW_COUNT-1:0] row_bits [ROW_COUNT];
    bit [LOCK_BITS-1:0] lock_count;
    sched_report_t      due_reports [$];
    int unsigned        errors;

    function void flag(string what, int unsigned want_v, int unsigned got_v);
      errors++;
      if (errors <= 10) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want_v, got_v);
      end
    endfunction

    function bit [PRIO_BITS-1:0] lowest_ready();
      bit [ROW_BITS-1:0] row;
      bit [ROW_BITS-1:0] col;
      row = '0;
      col = '0;
      if (group_bits == '0) return '0;
      while (row < ROW_COUNT - 1 && !group_bits[row]) row++;
      while (col < ROW_COUNT - 1 && !row_bits[row][col]) col++;
      return {row, col};
    endfunction

    function bit [PRIO_BITS-1:0] pick_ready();
      bit [PRIO_BITS-1:0] ready_list [$];
      for (int p = 0; p < 64; p++) begin
        if (row_bits[p / 8][p % 8]) ready_list.push_back(p);
      end
      if (ready_list.size() == 0) return $urandom_range(0, 63);
      return ready_list[$urandom_range(0, ready_list.size() - 1)];
    endfunction

    function void note_word(sched_word_t w);
      sched_report_t     r;
      bit [ROW_BITS-1:0] row;
      bit                sched;
      bit                gate_open;
      row = w.prio[5:3];
      sched = 1'b0;
      gate_open = w.run && !w.irq;
      case (w.mode)
        MODE_READY: begin
          group_bits[row] = 1'b1;
          row_bits[row][w.prio[2:0]] = 1'b1;
        end
        MODE_UNREADY: begin
          row_bits[row][w.prio[2:0]] = 1'b0;
          if (row_bits[row] == '0) group_bits[row] = 1'b0;
        end
        MODE_LOCK: begin
          if (gate_open && lock_count != LOCK_MAX) lock_count++;
        end
        MODE_UNLOCK: begin
          if (gate_open) begin
            if (lock_count != '0) lock_count--;
            sched = 1'b1;
          end
        end
        MODE_SCHED: sched = 1'b1;
        default: ;
      endcase
      r.highest = lowest_ready();
      r.empty = (group_bits == '0);
      r.switch_req = sched && !w.irq && lock_count == '0 && r.highest != w.cur;
      r.lock_level = lock_count;
      due_reports.push_back(r);
    endfunction

    function void check_report(sched_report_t got);
      sched_report_t want;
      if (due_reports.size() == 0) begin
        flag("unsolicited result, highest_prio", 0, got.highest);
        return;
      end
      want = due_reports.pop_front();
      if (got.highest !== want.highest) flag("highest_prio", want.highest, got.highest);
      if (got.empty !== want.empty) flag("none_ready", want.empty, got.empty);
      if (got.switch_req !== want.switch_req)
        flag("switch_needed", want.switch_req, got.switch_req);
      if (got.lock_level !== want.lock_level)
        flag("lock_level", want.lock_level, got.lock_level);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [MODE_BITS-1:0] in_mode = '0;
  logic [PRIO_BITS-1:0] in_priority_req = '0;
  logic [PRIO_BITS-1:0] in_current_prio = '0;
  logic                 in_in_interrupt = 1'b0;
  logic                 in_running = 1'b0;
  logic                 out_valid;
  logic [PRIO_BITS-1:0] out_highest_prio;
  logic                 out_none_ready;
  logic                 out_switch_needed;
  logic [LOCK_BITS-1:0] out_lock_level;

  ready_list_tracker sb = new();
  bit quiet;

  bitmap_priority_ready_scheduler_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_priority_req   (in_priority_req),
    .in_current_prio   (in_current_prio),
    .in_in_interrupt   (in_in_interrupt),
    .in_running        (in_running),
    .out_valid         (out_valid),
    .out_highest_prio  (out_highest_prio),
    .out_none_ready    (out_none_ready),
    .out_switch_needed (out_switch_needed),
    .out_lock_level    (out_lock_level)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[bitmap_priority_ready_scheduler_top] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_report('{out_highest_prio, out_none_ready, out_switch_needed, out_lock_level});
    end
  end

  function automatic int unsigned draw_gap();
    return quiet ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic send_word(input sched_word_t w);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_mode         <= w.mode;
    in_priority_req <= w.prio;
    in_current_prio <= w.cur;
    in_in_interrupt <= w.irq;
    in_running      <= w.run;
    do @(posedge clk); while (busy);
    sb.note_word(w);
  endtask

  task automatic drain_reports();
    start <= 1'b0;
    while (sb.due_reports.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(input bit [PRIO_BITS-1:0] pool_base, input int unsigned pool_span);
    sched_word_t w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    w.prio = $urandom_range(0, 63);
    w.cur = ($urandom_range(0, 1) == 0) ? sb.lowest_ready() : $urandom_range(0, 63);
    w.irq = ($urandom_range(0, 5) == 0);
    w.run = ($urandom_range(0, 7) != 0);
    if (pick < 30) begin
      w.mode = MODE_READY;
      if ($urandom_range(0, 3) != 0) w.prio = pool_base + $urandom_range(0, pool_span);
    end else if (pick < 55) begin
      w.mode = MODE_UNREADY;
      if ($urandom_range(0, 3) != 0) w.prio = sb.pick_ready();
    end else if (pick < 68) begin
      w.mode = MODE_LOCK;
    end else if (pick < 81) begin
      w.mode = MODE_UNLOCK;
    end else if (pick < 96) begin
      w.mode = MODE_SCHED;
    end else begin
      w.mode = $urandom_range(MODE_UNUSED_MIN, MODE_UNUSED_MAX);
    end
    send_word(w);
  endtask

  initial begin
    bit [PRIO_BITS-1:0] pool_base;
    int unsigned        pool_span;
    quiet = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, ready/unready corners, lock gating, unlock at zero, unused modes
    send_word('{MODE_SCHED,   6'd0,  6'd0,  1'b0, 1'b0});
    send_word('{MODE_SCHED,   6'd0,  6'd63, 1'b0, 1'b0});
    send_word('{MODE_READY,   6'd63, 6'd0,  1'b0, 1'b1});
    send_word('{MODE_READY,   6'd0,  6'd0,  1'b0, 1'b1});
    send_word('{MODE_SCHED,   6'd0,  6'd0,  1'b0, 1'b1});
    send_word('{MODE_UNREADY, 6'd0,  6'd0,  1'b0, 1'b1});
    send_word('{MODE_UNREADY, 6'd0,  6'd0,  1'b0, 1'b1});
    send_word('{MODE_READY,   6'd63, 6'd0,  1'b0, 1'b1});
    send_word('{MODE_LOCK,    6'd0,  6'd0,  1'b0, 1'b0});
    send_word('{MODE_LOCK,    6'd0,  6'd0,  1'b1, 1'b1});
    send_word('{MODE_LOCK,    6'd0,  6'd0,  1'b0, 1'b1});
    send_word('{MODE_SCHED,   6'd0,  6'd5,  1'b0, 1'b1});
    send_word('{MODE_UNLOCK,  6'd0,  6'd0,  1'b1, 1'b1});
    send_word('{MODE_UNLOCK,  6'd0,  6'd0,  1'b0, 1'b1});
    send_word('{MODE_UNLOCK,  6'd0,  6'd63, 1'b0, 1'b1});
    send_word('{MODE_UNLOCK,  6'd0,  6'd1,  1'b0, 1'b1});
    send_word('{MODE_SCHED,   6'd0,  6'd1,  1'b1, 1'b1});
    send_word('{3'd5,         6'd42, 6'd1,  1'b0, 1'b1});
    send_word('{3'd6,         6'd21, 6'd1,  1'b0, 1'b1});
    send_word('{3'd7,         6'd63, 6'd1,  1'b0, 1'b1});
    send_word('{MODE_READY,   6'd36, 6'd0,  1'b0, 1'b1});
    send_word('{MODE_READY,   6'd37, 6'd0,  1'b0, 1'b1});
    send_word('{MODE_UNREADY, 6'd36, 6'd0,  1'b0, 1'b1});
    send_word('{MODE_UNREADY, 6'd37, 6'd0,  1'b0, 1'b1});
    send_word('{MODE_UNREADY, 6'd63, 6'd0,  1'b0, 1'b1});

    // hold off until every outstanding result is back
    drain_reports();

    // drive the lock count into saturation and back down
    for (int i = 0; i < 520; i++) begin
      if (i % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_word('{(i < 260) ? MODE_LOCK : MODE_UNLOCK, 6'($urandom_range(0, 63)),
                  6'($urandom_range(0, 63)), 1'b0, 1'b1});
    end

    pool_base = '0;
    pool_span = 0;
    for (int i = 0; i < 1150; i++) begin
      if (i % 100 == 0) begin
        pool_base = $urandom_range(0, 63);
        pool_span = $urandom_range(0, 9);
        quiet = ($urandom_range(0, 3) == 0);
      end
      send_random(pool_base, pool_span);
    end

    drain_reports();
    repeat (12) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[bitmap_priority_ready_scheduler_top] OK");
    end else begin
      $display("[bitmap_priority_ready_scheduler_top] ERROR");
    end
    $finish;
  end
endmodule
